/* design/ios_pkg.sv */
// Package: shared types and state codes for interval overlap suppression.
`default_nettype none
package ios_pkg;

	localparam int IDX_W = 6;

	typedef struct packed {
		logic [31:0] weight;
		logic [15:0] support;
		logic [31:0] length;
		logic [31:0] start;
		logic [31:0] stop;
		logic        forward;
	} region_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BRD,
		ST_BLAT,
		ST_ARUN,
		ST_BEND,
		ST_SCAN,
		ST_EORD,
		ST_ERD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_b;
		logic cap_b;
		logic acc;
		logic b_end;
		logic scan;
		logic rd_ord;
		logic fill_out;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		logic in_last;
		logic a_done;
		logic b_last;
		logic slot_valid;
		logic out_fire;
		logic out_last;
	} status_t;

endpackage
`default_nettype wire

/* design/ios_region_if.sv */
// Interfaces: input region channel and kept region channel.
`default_nettype none
interface ios_region_if;
	logic        valid;
	logic        ready;
	logic [31:0] region_weight;
	logic [15:0] region_support;
	logic [31:0] region_length;
	logic [31:0] region_start;
	logic [31:0] region_end;
	logic        region_forward;
	logic        batch_last;

	modport source (output valid, region_weight, region_support, region_length,
		region_start, region_end, region_forward, batch_last, input ready);
	modport sink (input valid, region_weight, region_support, region_length,
		region_start, region_end, region_forward, batch_last, output ready);
endinterface

interface ios_kept_if;
	logic        valid;
	logic        ready;
	logic [5:0]  kept_index;
	logic [31:0] kept_start;
	logic [31:0] kept_end;
	logic        kept_forward;
	logic        kept_last;
	logic        batch_overflow;

	modport source (output valid, kept_index, kept_start, kept_end, kept_forward,
		kept_last, batch_overflow, input ready);
	modport sink (input valid, kept_index, kept_start, kept_end, kept_forward,
		kept_last, batch_overflow, output ready);
endinterface
`default_nettype wire

/* design/interval_overlap_suppression.sv */
// Top level: greedy interval suppression over a batch of candidate regions.
//
// Channels: "regions" (sink) takes one candidate region per item; "kept"
// (source) returns the surviving regions of a batch, in rank order.
// Items are accepted on valid && ready at a rising edge of clk.
//
// Loading: one region per cycle while the block is collecting a batch.
// Up to MAX_REGIONS regions are stored; extra ones are dropped and every
// result of that batch carries batch_overflow.
// The item with batch_last starts the pass. For each stored region b the
// store is streamed once: the count of regions ranked above b gives its
// rank, and any higher-ranked overlapping region on the same strand marks
// it eliminated. The pass is bound by the single read port of the region
// store. Emission then scans the rank slots, skipping eliminated ones, and
// reads each survivor into the output register, with kept_last on the last.
// Loading of the next batch starts after the last result is taken.
// A stalled receiver simply holds the output register; nothing is lost.
// Reset (arst_n low) empties the batch and drops any pending result.
`default_nettype none
module interval_overlap_suppression #(
	parameter int MAX_REGIONS = 64
) (
	input wire logic    clk,
	input wire logic    arst_n,
	ios_region_if.sink  regions,
	ios_kept_if.source  kept
);
	ios_pkg::cmd_t    cmd;
	ios_pkg::status_t st;

	// sequencer
	ios_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .st(st), .cmd(cmd)
	);

	// stores, comparators and output register
	ios_dpath #(.MAX_REGIONS(MAX_REGIONS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.regions(regions), .kept(kept)
	);
endmodule
`default_nettype wire

/* design/ios_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ios_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic [AW-1:0]         raddr,
	output logic      [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/ios_ctrl.sv */
// Controller: sequences load, pairwise rank/overlap pass and emission.
`default_nettype none
module ios_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ios_pkg::status_t st,
	output ios_pkg::cmd_t        cmd
);
	ios_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ios_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ios_pkg::ST_LOAD: if (st.in_fire && st.in_last) state_d = ios_pkg::ST_BRD;
			ios_pkg::ST_BRD:  state_d = ios_pkg::ST_BLAT;
			ios_pkg::ST_BLAT: state_d = ios_pkg::ST_ARUN;
			ios_pkg::ST_ARUN: if (st.a_done) state_d = ios_pkg::ST_BEND;
			ios_pkg::ST_BEND: state_d = st.b_last ? ios_pkg::ST_SCAN : ios_pkg::ST_BRD;
			ios_pkg::ST_SCAN: if (st.slot_valid) state_d = ios_pkg::ST_EORD;
			ios_pkg::ST_EORD: state_d = ios_pkg::ST_ERD;
			ios_pkg::ST_ERD:  state_d = ios_pkg::ST_EOUT;
			ios_pkg::ST_EOUT: begin
				if (st.out_fire) begin
					state_d = st.out_last ? ios_pkg::ST_LOAD : ios_pkg::ST_SCAN;
				end
			end
			default: state_d = ios_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ios_pkg::ST_LOAD: cmd.load = 1'b1;
			ios_pkg::ST_BRD:  cmd.rd_b = 1'b1;
			ios_pkg::ST_BLAT: cmd.cap_b = 1'b1;
			ios_pkg::ST_ARUN: cmd.acc = 1'b1;
			ios_pkg::ST_BEND: cmd.b_end = 1'b1;
			ios_pkg::ST_SCAN: cmd.scan = 1'b1;
			ios_pkg::ST_EORD: cmd.rd_ord = 1'b1;
			ios_pkg::ST_ERD:  cmd.fill_out = 1'b1;
			ios_pkg::ST_EOUT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

/* design/ios_dpath.sv */
// Datapath: region store, rank/overlap accumulator, rank-order table, output register.
`default_nettype none
module ios_dpath #(
	parameter int MAX_REGIONS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ios_pkg::cmd_t    cmd,
	output ios_pkg::status_t      st,
	ios_region_if.sink            regions,
	ios_kept_if.source            kept
);
	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

	logic [CW-1:0] cnt_q, b_q, a_q;
	logic          ovf_q;
	logic [AW-1:0] aprev_q, rank_q, slot_q, last_q, idx_q;
	logic          elim_q, seen_q;
	logic [MAX_REGIONS-1:0] valid_q;
	ios_pkg::region_t breg_q;

	ios_pkg::region_t wr_word, rd_word;
	logic          main_we;
	logic [AW-1:0] main_raddr;
	logic [AW-1:0] ord_rdata, ord_raddr;
	logic          ord_we;

	logic          in_fire, out_fire;
	logic          higher, overlap;

	logic          out_valid_q, out_last_q, out_fwd_q;
	logic [31:0]   out_start_q, out_end_q;
	logic [5:0]    out_idx_q;
	logic          out_ovf_q;

	assign in_fire  = regions.valid && regions.ready;
	assign out_fire = kept.valid && kept.ready;
	assign regions.ready = cmd.load;

	assign wr_word = '{weight: regions.region_weight, support: regions.region_support,
		length: regions.region_length, start: regions.region_start,
		stop: regions.region_end, forward: regions.region_forward};
	assign main_we = in_fire && (cnt_q < MAXC);

	always_comb begin
		main_raddr = a_q[AW-1:0];
		if (cmd.rd_b) begin
			main_raddr = b_q[AW-1:0];
		end else if (cmd.cap_b) begin
			main_raddr = '0;
		end else if (cmd.rd_ord) begin
			main_raddr = ord_rdata;
		end
	end

	ios_ram #(.WIDTH($bits(ios_pkg::region_t)), .DEPTH(MAX_REGIONS)) u_store (
		.clk(clk), .we(main_we), .waddr(cnt_q[AW-1:0]), .wdata(wr_word),
		.raddr(main_raddr), .rdata(rd_word)
	);

	assign ord_we    = cmd.b_end && !elim_q;
	assign ord_raddr = slot_q;

	ios_ram #(.WIDTH(AW), .DEPTH(MAX_REGIONS)) u_order (
		.clk(clk), .we(ord_we), .waddr(rank_q), .wdata(b_q[AW-1:0]),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	// rd_word is entry aprev_q; breg_q is the region under test
	always_comb begin
		higher = ({rd_word.weight, rd_word.support, rd_word.length} >
			{breg_q.weight, breg_q.support, breg_q.length}) ||
			(({rd_word.weight, rd_word.support, rd_word.length} ==
			{breg_q.weight, breg_q.support, breg_q.length}) &&
			({1'b0, aprev_q} < b_q));
		overlap = (rd_word.forward == breg_q.forward) &&
			!(breg_q.start > rd_word.stop) && !(rd_word.start > breg_q.stop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			b_q         <= '0;
			a_q         <= '0;
			seen_q      <= 1'b0;
			last_q      <= '0;
			slot_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (cnt_q < MAXC) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.cap_b) begin
				a_q <= CW'(1);
			end else if (cmd.acc && (a_q != cnt_q)) begin
				a_q <= a_q + 1'b1;
			end
			if (cmd.b_end) begin
				b_q <= b_q + 1'b1;
				if (!elim_q) begin
					valid_q[rank_q] <= 1'b1;
					if (!seen_q || rank_q > last_q) begin
						last_q <= rank_q;
					end
					seen_q <= 1'b1;
				end
			end
			if (cmd.scan && !valid_q[slot_q]) begin
				slot_q <= slot_q + 1'b1;
			end
			if (cmd.fill_out) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.emit && out_fire) begin
				out_valid_q <= 1'b0;
				if (out_last_q) begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					b_q     <= '0;
					seen_q  <= 1'b0;
					last_q  <= '0;
					slot_q  <= '0;
					valid_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_b) begin
			aprev_q <= '0;
		end
		if (cmd.cap_b) begin
			breg_q  <= rd_word;
			aprev_q <= '0;
			rank_q  <= '0;
			elim_q  <= 1'b0;
		end
		if (cmd.acc) begin
			rank_q <= rank_q + AW'(higher);
			elim_q <= elim_q | (higher & overlap);
			if (a_q != cnt_q) begin
				aprev_q <= a_q[AW-1:0];
			end
		end
		if (cmd.rd_ord) begin
			idx_q <= ord_rdata;
		end
		if (cmd.fill_out) begin
			out_idx_q   <= 6'(idx_q);
			out_start_q <= rd_word.start;
			out_end_q   <= rd_word.stop;
			out_fwd_q   <= rd_word.forward;
			out_last_q  <= (slot_q == last_q);
			out_ovf_q   <= ovf_q;
		end
	end

	assign kept.valid          = out_valid_q;
	assign kept.kept_index     = out_idx_q;
	assign kept.kept_start     = out_start_q;
	assign kept.kept_end       = out_end_q;
	assign kept.kept_forward   = out_fwd_q;
	assign kept.kept_last      = out_last_q;
	assign kept.batch_overflow = out_ovf_q;

	assign st.in_fire    = in_fire;
	assign st.in_last    = regions.batch_last;
	assign st.a_done     = (a_q == cnt_q);
	assign st.b_last     = (b_q == cnt_q - 1'b1);
	assign st.slot_valid = valid_q[slot_q];
	assign st.out_fire   = out_fire;
	assign st.out_last   = out_last_q;
endmodule
`default_nettype wire

/* sim/interval_overlap_suppression_checker.sv */
// Checker: predicts the kept regions of each batch and compares them with the block's results.
`timescale 1ns / 1ps
module interval_overlap_suppression_checker #(
	parameter int MAX_REGIONS = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	ios_region_if regions,
	ios_kept_if   kept,
	output int    fail_count,
	output int    pending,
	output int    kept_count,
	output int    batch_count
);

	typedef struct packed {
		logic [5:0]  idx;
		logic [31:0] start;
		logic [31:0] stop;
		logic        forward;
		logic        last;
		logic        overflow;
	} kept_t;

	ios_pkg::region_t held [MAX_REGIONS];
	int      held_n;
	bit      dropped;
	kept_t   survivors_q [$];

	function automatic bit outranks(ios_pkg::region_t a, ios_pkg::region_t b);
		if (a.weight != b.weight) return a.weight > b.weight;
		if (a.support != b.support) return a.support > b.support;
		return a.length > b.length;
	endfunction

	function automatic bit overlaps(ios_pkg::region_t a, ios_pkg::region_t b);
		if (a.forward != b.forward) return 0;
		if (b.start > a.stop || a.start > b.stop) return 0;
		return 1;
	endfunction

	// rank the batch (stable), knock out lower-ranked overlaps, queue survivors
	task automatic suppress_batch();
		int    order [MAX_REGIONS];
		bit    gone [MAX_REGIONS];
		int    j;
		int    last_rank;
		kept_t k;
		for (int i = 0; i < held_n; i++) begin
			j = i;
			while (j > 0 && outranks(held[i], held[order[j-1]])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
			gone[i] = 0;
		end
		for (int i = 0; i < held_n; i++)
			for (int m = i + 1; m < held_n; m++)
				if (overlaps(held[order[i]], held[order[m]]))
					gone[m] = 1;
		last_rank = 0;
		for (int i = 0; i < held_n; i++)
			if (!gone[i]) last_rank = i;
		for (int i = 0; i < held_n; i++) begin
			if (!gone[i]) begin
				k.idx      = order[i][5:0];
				k.start    = held[order[i]].start;
				k.stop     = held[order[i]].stop;
				k.forward  = held[order[i]].forward;
				k.last     = (i == last_rank);
				k.overflow = dropped;
				survivors_q.push_back(k);
			end
		end
		held_n  = 0;
		dropped = 0;
		batch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		kept_t   want;
		kept_t   got;
		ios_pkg::region_t r;
		if (!arst_n) begin
			held_n      = 0;
			dropped     = 0;
			survivors_q.delete();
			fail_count  = 0;
			kept_count  = 0;
			batch_count = 0;
			pending     = 0;
		end else begin
			if (kept.valid && kept.ready) begin
				kept_count++;
				got = '{kept.kept_index, kept.kept_start, kept.kept_end,
					kept.kept_forward, kept.kept_last, kept.batch_overflow};
				if (survivors_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result %p", $realtime, got);
				end else begin
					want = survivors_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch expected %p actual %p",
								$realtime, want, got);
					end
				end
			end
			if (regions.valid && regions.ready) begin
				r = '{regions.region_weight, regions.region_support,
					regions.region_length, regions.region_start,
					regions.region_end, regions.region_forward};
				if (held_n < MAX_REGIONS) begin
					held[held_n] = r;
					held_n++;
				end else begin
					dropped = 1;
				end
				if (regions.batch_last) suppress_batch();
			end
			pending = survivors_q.size();
		end
	end

endmodule

/* sim/interval_overlap_suppression_tb.sv */
// Testbench top: drives region batches, applies back-pressure and reports the verdict.
`timescale 1ns / 1ps
module interval_overlap_suppression_tb;

	logic clk;
	logic arst_n;

	ios_region_if regions ();
	ios_kept_if   kept ();

	int fail_count;
	int pending;
	int kept_count;
	int batch_count;

	int tx_idle;       // percent of cycles the sender holds back
	int rx_idle;       // percent of cycles the receiver holds back
	bit hold_off;      // long receiver stall, see below
	int items_sent;

	interval_overlap_suppression #(.MAX_REGIONS(64)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.regions(regions),
		.kept   (kept)
	);

	interval_overlap_suppression_checker #(.MAX_REGIONS(64)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.regions    (regions),
		.kept       (kept),
		.fail_count (fail_count),
		.pending    (pending),
		.kept_count (kept_count),
		.batch_count(batch_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random stalls, plus the long hold-off when requested
	always @(posedge clk) begin
		kept.ready <= !hold_off && ($urandom_range(0, 99) >= rx_idle);
	end

	// long hold-off: the sender keeps offering, so the block fills and
	// must stall its input until results drain again
	initial begin
		hold_off = 0;
		wait (items_sent >= 100);
		@(posedge clk);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", pending);
		$display("== FAIL ==");
		$finish;
	end

	function automatic ios_pkg::region_t mk(logic [31:0] w, logic [15:0] s, logic [31:0] l,
		logic [31:0] st, logic [31:0] sp, logic f);
		ios_pkg::region_t r;
		r = '{w, s, l, st, sp, f};
		return r;
	endfunction

	// random region: small key ranges so ties and overlaps are common,
	// with the odd full-width value to exercise every bit
	function automatic ios_pkg::region_t rand_region();
		ios_pkg::region_t r;
		r.weight  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
		r.support = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2));
		r.length  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
		if ($urandom_range(0, 9) == 0) begin
			r.start = $urandom;
			r.stop  = $urandom;
		end else begin
			r.start = $urandom_range(0, 400);
			r.stop  = ($urandom_range(0, 9) == 0) ? r.start - $urandom_range(0, 20)
				: r.start + $urandom_range(0, 40);
		end
		r.forward = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send_region(ios_pkg::region_t r, bit last);
		while ($urandom_range(0, 99) < tx_idle) begin
			regions.valid <= 1'b0;
			@(posedge clk);
		end
		regions.valid          <= 1'b1;
		regions.region_weight  <= r.weight;
		regions.region_support <= r.support;
		regions.region_length  <= r.length;
		regions.region_start   <= r.start;
		regions.region_end     <= r.stop;
		regions.region_forward <= r.forward;
		regions.batch_last     <= last;
		@(posedge clk);
		while (!regions.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic set_idling();
		if (items_sent < 180) begin
			tx_idle = 29;
			rx_idle = 83;
		end else if (items_sent < 360) begin
			tx_idle = 83;
			rx_idle = 29;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	endtask

	initial begin
		int size;
		int last_at;
		int nb;
		arst_n     = 1'b0;
		items_sent = 0;
		tx_idle    = 29;
		rx_idle    = 83;
		regions.valid          <= 1'b0;
		regions.region_weight  <= '0;
		regions.region_support <= '0;
		regions.region_length  <= '0;
		regions.region_start   <= '0;
		regions.region_end     <= '0;
		regions.region_forward <= 1'b0;
		regions.batch_last     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-region batches at the field extremes
		send_region(mk('1, '1, '1, '1, '1, 1'b1), 1'b1);
		send_region(mk('0, '0, '0, '0, '0, 1'b0), 1'b1);

		// ties keep load order; support then length break weight ties
		send_region(mk(32'd5, 16'd1, 32'd1, 32'd10, 32'd20, 1'b1), 1'b0);
		send_region(mk(32'd5, 16'd1, 32'd1, 32'd30, 32'd40, 1'b1), 1'b0);
		send_region(mk(32'd5, 16'd2, 32'd1, 32'd50, 32'd60, 1'b1), 1'b0);
		send_region(mk(32'd5, 16'd1, 32'd9, 32'd70, 32'd80, 1'b1), 1'b0);
		// touching ends overlap; other strand is untouched
		send_region(mk(32'd4, 16'd0, 32'd0, 32'd100, 32'd200, 1'b0), 1'b0);
		send_region(mk(32'd3, 16'd0, 32'd0, 32'd200, 32'd300, 1'b0), 1'b0);
		send_region(mk(32'd2, 16'd0, 32'd0, 32'd200, 32'd300, 1'b1), 1'b0);
		// end before start: compared as given
		send_region(mk(32'd2, 16'd0, 32'd0, 32'd400, 32'd350, 1'b0), 1'b0);
		send_region(mk(32'd1, 16'd0, 32'd0, 32'd360, 32'd380, 1'b0), 1'b0);
		// an eliminated region still knocks out the next one in the chain
		send_region(mk(32'd9, 16'd0, 32'd0, 32'd1000, 32'd1100, 1'b1), 1'b0);
		send_region(mk(32'd8, 16'd0, 32'd0, 32'd1090, 32'd1200, 1'b1), 1'b0);
		send_region(mk(32'd7, 16'd0, 32'd0, 32'd1150, 32'd1300, 1'b1), 1'b1);

		// random batches: mostly small, a full store, and two overflows
		// (each ending on a dropped item)
		nb = 0;
		while (items_sent < 520) begin
			set_idling();
			if (nb == 6) begin
				size    = 64;
				last_at = 64;
			end else if (nb == 25) begin
				size    = 66;
				last_at = 66;
			end else if (nb == 45) begin
				size    = 70;
				last_at = 70;
			end else begin
				size    = $urandom_range(1, 10);
				last_at = size;
			end
			for (int i = 1; i <= size; i++)
				send_region(rand_region(), i == last_at);
			nb++;
		end
		regions.valid <= 1'b0;

		// let the checker see the final batch before polling its queue
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d items in %0d batches, %0d kept regions checked",
			items_sent, batch_count, kept_count);
		$display("full store and overflow batches included, with a long output stall");
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/ios_pkg.sv
design/ios_region_if.sv
design/ios_ram.sv
design/ios_ctrl.sv
design/ios_dpath.sv
design/interval_overlap_suppression.sv
sim/interval_overlap_suppression_checker.sv
sim/interval_overlap_suppression_tb.sv
